// ===== src/elhs_pkg.sv =====
// Shared types, codes, constants and helper functions of the lift move and home sequencer.
package elhs_pkg;

	localparam int COUNT_BITS       = 32;
	localparam int DRIVE_FULL_SCALE = 400;

	localparam int WIDE_BITS    = (COUNT_BITS > 32) ? COUNT_BITS : 32;
	localparam int MAG_BITS     = (COUNT_BITS > 31) ? COUNT_BITS : 31;
	localparam int ELAPSED_BITS = 17;
	localparam int DRIVE_BITS   = 10;
	localparam int CLAMP_BITS   = 17;

	localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;
	localparam logic signed [CLAMP_BITS-1:0] DRIVE_FS = CLAMP_BITS'(DRIVE_FULL_SCALE);

	localparam logic [15:0] MOVE_TIMEOUT_RESET = 16'd15000;
	localparam logic [15:0] HOME_TIMEOUT_RESET = 16'd30000;
	localparam logic [8:0]  HOME_SPEED_RESET   = 9'd150;
	localparam logic [31:0] SAFE_COUNT_RESET   = 32'd0;

	localparam logic [2:0] CMD_SAMPLE    = 3'd0;
	localparam logic [2:0] CMD_MOVE      = 3'd1;
	localparam logic [2:0] CMD_HOME      = 3'd2;
	localparam logic [2:0] CMD_BELT_RUN  = 3'd3;
	localparam logic [2:0] CMD_BELT_STOP = 3'd4;
	localparam logic [2:0] CMD_ESTOP     = 3'd5;

	localparam logic [2:0] EV_NONE         = 3'd0;
	localparam logic [2:0] EV_MOVE_DONE    = 3'd1;
	localparam logic [2:0] EV_MOVE_TIMEOUT = 3'd2;
	localparam logic [2:0] EV_FAULT        = 3'd3;
	localparam logic [2:0] EV_HOME_DONE    = 3'd4;
	localparam logic [2:0] EV_HOME_TIMEOUT = 3'd5;

	localparam logic [1:0] REG_MOVE_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_HOME_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_HOME_SPEED   = 2'd2;
	localparam logic [1:0] REG_SAFE_COUNT   = 2'd3;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic signed [WIDE_BITS-1:0] wide_t;
	typedef logic signed [DRIVE_BITS-1:0] drive_t;

	function automatic wide_t count_wide(input count_t c);
		return WIDE_BITS'(signed'(c));
	endfunction

	function automatic wide_t safe_wide(input logic signed [31:0] s);
		return WIDE_BITS'(s);
	endfunction

	function automatic count_t safe_to_count(input logic signed [31:0] s);
		wide_t w;
		w = WIDE_BITS'(s);
		return w[COUNT_BITS-1:0];
	endfunction

	function automatic logic [31:0] count_out(input count_t c);
		logic [WIDE_BITS-1:0] w;
		w = WIDE_BITS'(c);
		return w[31:0];
	endfunction

	function automatic logic [MAG_BITS-1:0] count_mag(input count_t c);
		count_t m;
		m = c[COUNT_BITS-1] ? (~c + 1'b1) : c;
		return MAG_BITS'(m);
	endfunction

	function automatic drive_t clamp_drive(input logic signed [CLAMP_BITS-1:0] v);
		logic signed [CLAMP_BITS-1:0] r;
		if (v > DRIVE_FS) begin
			r = DRIVE_FS;
		end else if (v < -DRIVE_FS) begin
			r = -DRIVE_FS;
		end else begin
			r = v;
		end
		return r[DRIVE_BITS-1:0];
	endfunction

endpackage

// ===== src/elhs_in_if.sv =====
// Input channel of the sequencer: valid, ready and one sample item.
interface elhs_in_if import elhs_pkg::*; ();
	logic         valid;
	logic         ready;
	logic [2:0]   cmd;
	logic         chan_a;
	logic         chan_b;
	logic         ms_tick;
	logic         lift_fault;
	logic         belt_fault;
	logic [30:0]  move_target;
	drive_t       drive_value;

	modport source (
		output valid, cmd, chan_a, chan_b, ms_tick, lift_fault, belt_fault,
		       move_target, drive_value,
		input  ready
	);
	modport sink (
		input  valid, cmd, chan_a, chan_b, ms_tick, lift_fault, belt_fault,
		       move_target, drive_value,
		output ready
	);
endinterface

// ===== src/elhs_out_if.sv =====
// Result channel of the sequencer: valid, ready and one status item.
interface elhs_out_if import elhs_pkg::*; ();
	logic         valid;
	logic         ready;
	drive_t       lift_drive;
	drive_t       belt_drive;
	logic [31:0]  count_now;
	logic [31:0]  saved_count;
	logic         busy_res;
	logic         halted;
	logic [2:0]   event_res;

	modport source (
		output valid, lift_drive, belt_drive, count_now, saved_count, busy_res, halted,
		       event_res,
		input  ready
	);
	modport sink (
		input  valid, lift_drive, belt_drive, count_now, saved_count, busy_res, halted,
		       event_res,
		output ready
	);
endinterface

// ===== src/encoder_lift_move_and_home_sequencer.sv =====
// Lift move and home sequencer: encoder counting, move, home, belt and emergency control.
//
// Each transfer on in_ch is one sample of the encoder pins, ms tick, fault pins and a command;
// it produces exactly one status transfer on out_ch via the input and output registers. One
// item per clock is sustained while out_ch is ready: the item is captured in an input
// register, all decoding, command handling and move/home checks are one combinational pass,
// and the result lands in the output register. in_ch.ready drops only while both registers
// hold data that out_ch has not taken. Timeouts, home speed and safe count are written through
// cfg_we, cfg_idx, cfg_data, but only while no item is in flight: a user rule, not enforced.
// After emergency home it reports halted and ignores commands until reset; encoder counts on.
module encoder_lift_move_and_home_sequencer import elhs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	elhs_in_if.sink     in_ch,
	elhs_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_data
);

	typedef enum logic [1:0] {MODE_IDLE, MODE_MOVE, MODE_HOME} mode_t;

	// configuration
	logic [15:0]        move_timeout_q;
	logic [15:0]        home_timeout_q;
	logic [8:0]         home_speed_q;
	logic signed [31:0] safe_count_q;

	// input stage
	logic        valid_s1;
	logic [2:0]  cmd_s1;
	logic        chan_a_s1;
	logic        chan_b_s1;
	logic        ms_tick_s1;
	logic        lift_fault_s1;
	logic        belt_fault_s1;
	logic [30:0] move_target_s1;
	drive_t      drive_value_s1;

	// block state
	count_t                  count_q, count_d;
	count_t                  saved_q, saved_d;
	logic                    last_a_q;
	mode_t                   mode_q, mode_d;
	logic [ELAPSED_BITS-1:0] elapsed_q, elapsed_d;
	logic [30:0]             target_q, target_d;
	drive_t                  lift_q, lift_d;
	drive_t                  belt_q, belt_d;
	logic                    home_dir_q, home_dir_d;
	logic                    emerg_q, emerg_d;
	logic                    halt_q, halt_d;
	logic [2:0]              event_d;

	// result stage
	logic        out_valid_s2;
	drive_t      lift_drive_s2;
	drive_t      belt_drive_s2;
	logic [31:0] count_now_s2;
	logic [31:0] saved_count_s2;
	logic        busy_s2;
	logic        halted_s2;
	logic [2:0]  event_s2;

	logic   adv;
	logic   take;
	logic   up;
	logic   do_home;
	logic   going;
	drive_t drv_c;
	drive_t hs_c;
	wide_t  safe_w;
	wide_t  saved_w;
	wide_t  cnt_w;

	assign adv  = valid_s1 && (!out_valid_s2 || out_ch.ready);
	assign take = in_ch.valid && in_ch.ready;
	assign in_ch.ready = !valid_s1 || adv;

	assign out_ch.valid       = out_valid_s2;
	assign out_ch.lift_drive  = lift_drive_s2;
	assign out_ch.belt_drive  = belt_drive_s2;
	assign out_ch.count_now   = count_now_s2;
	assign out_ch.saved_count = saved_count_s2;
	assign out_ch.busy_res    = busy_s2;
	assign out_ch.halted      = halted_s2;
	assign out_ch.event_res   = event_s2;

	assign drv_c   = clamp_drive(CLAMP_BITS'(drive_value_s1));
	assign hs_c    = clamp_drive(CLAMP_BITS'(signed'({1'b0, home_speed_q})));
	assign safe_w  = safe_wide(safe_count_q);
	assign saved_w = count_wide(saved_q);
	assign up      = chan_a_s1 ? !chan_b_s1 : chan_b_s1;

	always_comb begin
		count_d    = count_q;
		saved_d    = saved_q;
		mode_d     = mode_q;
		elapsed_d  = elapsed_q;
		target_d   = target_q;
		lift_d     = lift_q;
		belt_d     = belt_q;
		home_dir_d = home_dir_q;
		emerg_d    = emerg_q;
		halt_d     = halt_q;
		event_d    = EV_NONE;
		do_home    = 1'b0;
		going      = 1'b0;

		if (chan_a_s1 != last_a_q) begin
			count_d = up ? count_q + 1'b1 : count_q - 1'b1;
		end

		if (mode_q != MODE_IDLE && ms_tick_s1 && elapsed_q < ELAPSED_MAX) begin
			elapsed_d = elapsed_q + 1'b1;
		end

		if (!halt_q) begin
			if (cmd_s1 == CMD_ESTOP) begin
				if (!emerg_q) begin
					lift_d  = '0;
					belt_d  = '0;
					do_home = 1'b1;
					emerg_d = 1'b1;
				end
			end else if (mode_q == MODE_IDLE) begin
				case (cmd_s1)
					CMD_MOVE: begin
						count_d   = '0;
						lift_d    = drv_c;
						target_d  = move_target_s1;
						elapsed_d = '0;
						mode_d    = MODE_MOVE;
					end
					CMD_HOME:      do_home = 1'b1;
					CMD_BELT_RUN:  belt_d  = drv_c;
					CMD_BELT_STOP: belt_d  = '0;
					default: ;
				endcase
			end
		end

		if (do_home) begin
			count_d    = saved_q;
			elapsed_d  = '0;
			mode_d     = MODE_HOME;
			home_dir_d = 1'b0;
			if (safe_w < saved_w) begin
				lift_d = hs_c;
			end else if (saved_w < safe_w) begin
				lift_d     = -hs_c;
				home_dir_d = 1'b1;
			end
		end

		cnt_w = count_wide(count_d);

		case (mode_d)
			MODE_MOVE: begin
				if (count_mag(count_d) >= MAG_BITS'(target_d)) begin
					lift_d  = '0;
					saved_d = count_d;
					event_d = EV_MOVE_DONE;
				end else if (elapsed_d > ELAPSED_BITS'(move_timeout_q)) begin
					lift_d  = '0;
					saved_d = count_d;
					event_d = EV_MOVE_TIMEOUT;
				end else if (lift_fault_s1 || belt_fault_s1) begin
					lift_d  = '0;
					belt_d  = '0;
					saved_d = count_d;
					event_d = EV_FAULT;
				end
				if (event_d != EV_NONE) begin
					mode_d = MODE_IDLE;
				end
			end
			MODE_HOME: begin
				going = home_dir_d ? (cnt_w < safe_w) : (safe_w < cnt_w);
				if (!going) begin
					lift_d  = '0;
					count_d = safe_to_count(safe_count_q);
					saved_d = safe_to_count(safe_count_q);
					event_d = EV_HOME_DONE;
				end else if (elapsed_d > ELAPSED_BITS'(home_timeout_q)) begin
					lift_d  = '0;
					event_d = EV_HOME_TIMEOUT;
				end else if (lift_fault_s1 || belt_fault_s1) begin
					lift_d  = '0;
					belt_d  = '0;
					saved_d = count_d;
					event_d = EV_FAULT;
				end
				if (event_d != EV_NONE) begin
					mode_d = MODE_IDLE;
					if (emerg_d) begin
						emerg_d = 1'b0;
						halt_d  = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_timeout_q <= MOVE_TIMEOUT_RESET;
			home_timeout_q <= HOME_TIMEOUT_RESET;
			home_speed_q   <= HOME_SPEED_RESET;
			safe_count_q   <= SAFE_COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MOVE_TIMEOUT: move_timeout_q <= cfg_data[15:0];
				REG_HOME_TIMEOUT: home_timeout_q <= cfg_data[15:0];
				REG_HOME_SPEED:   home_speed_q   <= cfg_data[8:0];
				REG_SAFE_COUNT:   safe_count_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1         <= in_ch.cmd;
			chan_a_s1      <= in_ch.chan_a;
			chan_b_s1      <= in_ch.chan_b;
			ms_tick_s1     <= in_ch.ms_tick;
			lift_fault_s1  <= in_ch.lift_fault;
			belt_fault_s1  <= in_ch.belt_fault;
			move_target_s1 <= in_ch.move_target;
			drive_value_s1 <= in_ch.drive_value;
		end
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			saved_q        <= '0;
			last_a_q       <= 1'b0;
			mode_q         <= MODE_IDLE;
			elapsed_q      <= '0;
			target_q       <= '0;
			lift_q         <= '0;
			belt_q         <= '0;
			home_dir_q     <= 1'b0;
			emerg_q        <= 1'b0;
			halt_q         <= 1'b0;
			lift_drive_s2  <= '0;
			belt_drive_s2  <= '0;
			count_now_s2   <= '0;
			saved_count_s2 <= '0;
			busy_s2        <= 1'b0;
			halted_s2      <= 1'b0;
			event_s2       <= EV_NONE;
			out_valid_s2   <= 1'b0;
		end else begin
			if (adv) begin
				count_q        <= count_d;
				saved_q        <= saved_d;
				last_a_q       <= chan_a_s1;
				mode_q         <= mode_d;
				elapsed_q      <= elapsed_d;
				target_q       <= target_d;
				lift_q         <= lift_d;
				belt_q         <= belt_d;
				home_dir_q     <= home_dir_d;
				emerg_q        <= emerg_d;
				halt_q         <= halt_d;
				lift_drive_s2  <= lift_d;
				belt_drive_s2  <= belt_d;
				count_now_s2   <= count_out(count_d);
				saved_count_s2 <= count_out(saved_d);
				busy_s2        <= (mode_d != MODE_IDLE);
				halted_s2      <= halt_d;
				event_s2       <= event_d;
				out_valid_s2   <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

endmodule
